@@ hw/rtl/lts_pkg.sv @@
// Shared types, token codes, character codes and keyword table for the token scanner.
package lts_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_STR,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_WORD,
        MODE_DISCARD
    } mode_t;

    localparam logic [5:0] KIND_PLUS    = 6'd0;
    localparam logic [5:0] KIND_MINUS   = 6'd1;
    localparam logic [5:0] KIND_STAR    = 6'd2;
    localparam logic [5:0] KIND_SLASH   = 6'd3;
    localparam logic [5:0] KIND_ASSIGN  = 6'd4;
    localparam logic [5:0] KIND_SEMI    = 6'd12;
    localparam logic [5:0] KIND_COMMA   = 6'd13;
    localparam logic [5:0] KIND_LPAREN  = 6'd14;
    localparam logic [5:0] KIND_RPAREN  = 6'd15;
    localparam logic [5:0] KIND_LBRACE  = 6'd16;
    localparam logic [5:0] KIND_RBRACE  = 6'd17;
    localparam logic [5:0] KIND_STRING  = 6'd18;
    localparam logic [5:0] KIND_NUMBER  = 6'd19;
    localparam logic [5:0] KIND_IDENT   = 6'd20;
    localparam logic [5:0] KIND_LET     = 6'd21;
    localparam logic [5:0] KIND_END     = 6'd33;
    localparam logic [5:0] KIND_BADCHAR = 6'd34;
    localparam logic [5:0] KIND_UNTERM  = 6'd35;

    localparam logic [1:0] OP_EQ   = 2'd0;
    localparam logic [1:0] OP_BANG = 2'd1;
    localparam logic [1:0] OP_LT   = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam int KEYWORD_MAX_CHARS = 8;
    localparam int KW_COUNT          = 12;
    localparam int WLEN_W            = 4;

    // Keyword text, right-justified: the first character sits in the highest used byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "let", "var", "print", "true", "false", "and",
        "or", "return", "function", "if", "else", "while"
    };
    localparam logic [WLEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd3, 4'd5, 4'd4, 4'd5, 4'd3,
        4'd2, 4'd6, 4'd8, 4'd2, 4'd4, 4'd5
    };

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;
    localparam int MAX_RECS    = 3;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] line;
        logic [7:0]  offending;
        logic        run_end;
    } rec_t;

    typedef struct packed {
        logic not_empty;
        logic room;
    } q_status_t;

    // Word buffer holds the first character in its lowest byte.
    function automatic logic [5:0] keyword_kind(input logic [63:0] wbuf,
                                                input logic [WLEN_W-1:0] wlen);
        logic [5:0]        kind;
        logic              hit;
        logic [63:0]       lit;
        logic [WLEN_W-1:0] n;
        kind = KIND_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            lit = KW_TEXT[i];
            n   = KW_LEN[i];
            hit = (wlen == n);
            for (int j = 0; j < KEYWORD_MAX_CHARS; j++) begin
                if (j < int'(n)) begin
                    hit = hit && (wbuf[8*j +: 8] == lit[8*(int'(n) - 1 - j) +: 8]);
                end
                else begin
                    hit = hit && (wbuf[8*j +: 8] == 8'h00);
                end
            end
            if (hit) begin
                kind = KIND_LET + 6'(i);
            end
        end
        return kind;
    endfunction

endpackage

@@ hw/rtl/lts_scan.sv @@
// Scan state and combinational record generation for one source word.
module lts_scan #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [7:0]                 src_byte,
    input  logic                       src_final,
    output lts_pkg::rec_t [2:0]        recs,
    output logic [1:0]                 rec_count
);
    import lts_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int EW = (PW + 1 > 33) ? PW + 1 : 33;

    mode_t              mode_reg, mode_next, a_mode, b_mode;
    logic [1:0]         pend_reg, pend_next, b_pend;
    logic [PW-1:0]      begin_reg, begin_next, b_begin;
    logic [PW-1:0]      pos_reg, pos_next, pos_sat, pos_m1;
    logic [31:0]        line_reg, line_next, b_line;
    logic [63:0]        wbuf_reg, wbuf_next, a_wbuf, b_wbuf;
    logic [WLEN_W-1:0]  wlen_reg, wlen_next, a_wlen, b_wlen;
    logic               a_restart, b_run;

    logic is_digit, is_letter, is_eq, is_dot, is_quote, is_nl, is_blank;
    logic is_single, is_op, is_bad;
    logic [5:0] single_kind;
    logic [1:0] op_code;

    logic [EW-1:0] p_ext, p1_ext, pm1_ext, pe_ext, begin_ext, b_begin_ext;
    logic [5:0]    op_kind_a, op_kind_b;

    rec_t       cand [5];
    logic [4:0] cand_v;
    logic [2:0] idx;

    function automatic rec_t mk_rec(input logic [5:0] kind, input logic [EW-1:0] start,
                                    input logic [EW-1:0] stop, input logic [31:0] line,
                                    input logic [7:0] off);
        rec_t          r;
        logic [EW-1:0] diff;
        diff        = stop - start;
        r.kind      = kind;
        r.start     = start[31:0];
        r.length    = (stop < start) ? 32'd0 : ((|diff[EW-1:32]) ? '1 : diff[31:0]);
        r.line      = line;
        r.offending = off;
        r.run_end   = 1'b0;
        return r;
    endfunction

    // Character classes
    assign is_digit  = (src_byte >= 8'h30) && (src_byte <= 8'h39);
    assign is_letter = ((src_byte >= 8'h61) && (src_byte <= 8'h7A)) ||
                       ((src_byte >= 8'h41) && (src_byte <= 8'h5A)) ||
                       (src_byte == CH_UNDER);
    assign is_eq     = (src_byte == CH_EQ);
    assign is_dot    = (src_byte == CH_DOT);
    assign is_quote  = (src_byte == CH_QUOTE);
    assign is_nl     = (src_byte == CH_NL);
    assign is_blank  = (src_byte == CH_SPACE) || (src_byte == CH_CR) || (src_byte == CH_TAB);

    always_comb begin
        is_single   = 1'b1;
        single_kind = KIND_PLUS;
        unique case (src_byte)
            CH_PLUS:   single_kind = KIND_PLUS;
            CH_MINUS:  single_kind = KIND_MINUS;
            CH_STAR:   single_kind = KIND_STAR;
            CH_SLASH:  single_kind = KIND_SLASH;
            CH_SEMI:   single_kind = KIND_SEMI;
            CH_COMMA:  single_kind = KIND_COMMA;
            CH_LPAREN: single_kind = KIND_LPAREN;
            CH_RPAREN: single_kind = KIND_RPAREN;
            CH_LBRACE: single_kind = KIND_LBRACE;
            CH_RBRACE: single_kind = KIND_RBRACE;
            default:   is_single = 1'b0;
        endcase
    end

    always_comb begin
        is_op   = 1'b1;
        op_code = OP_EQ;
        unique case (src_byte)
            CH_EQ:   op_code = OP_EQ;
            CH_BANG: op_code = OP_BANG;
            CH_LT:   op_code = OP_LT;
            CH_GT:   op_code = OP_GT;
            default: is_op = 1'b0;
        endcase
    end

    assign is_bad = !(is_single || is_op || is_quote || is_blank || is_nl ||
                      is_digit || is_letter);

    // Positions, widened so that end offsets one past the top still fit
    assign pos_sat     = (pos_reg != '1) ? pos_reg + PW'(1) : pos_reg;
    assign pos_m1      = pos_reg - PW'(1);
    assign p_ext       = EW'(pos_reg);
    assign p1_ext      = p_ext + EW'(1);
    assign pm1_ext     = EW'(pos_m1);
    assign pe_ext      = EW'(pos_sat);
    assign begin_ext   = EW'(begin_reg);
    assign b_begin_ext = EW'(b_begin);
    assign op_kind_a   = KIND_ASSIGN + 6'({pend_reg, 1'b0});
    assign op_kind_b   = KIND_ASSIGN + 6'({b_pend, 1'b0});

    // Continue the open token
    always_comb begin
        a_mode    = mode_reg;
        a_restart = 1'b0;
        a_wbuf    = wbuf_reg;
        a_wlen    = wlen_reg;
        unique case (mode_reg)
            MODE_OP:
            begin
                a_mode    = MODE_IDLE;
                a_restart = !is_eq;
            end
            MODE_STR:
            begin
                if (is_quote) a_mode = MODE_IDLE;
            end
            MODE_INT:
            begin
                if (is_dot) begin
                    a_mode = MODE_DOT;
                end
                else if (!is_digit) begin
                    a_mode    = MODE_IDLE;
                    a_restart = 1'b1;
                end
            end
            MODE_DOT:
            begin
                a_mode = is_digit ? MODE_FRAC : MODE_DISCARD;
            end
            MODE_FRAC:
            begin
                if (!is_digit) begin
                    a_mode    = MODE_IDLE;
                    a_restart = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (is_letter || is_digit) begin
                    if (wlen_reg < WLEN_W'(KEYWORD_MAX_CHARS)) begin
                        a_wbuf[{wlen_reg[2:0], 3'b000} +: 8] = src_byte;
                        a_wlen = wlen_reg + WLEN_W'(1);
                    end
                    else begin
                        a_wlen = WLEN_W'(KEYWORD_MAX_CHARS + 1);
                    end
                end
                else begin
                    a_mode    = MODE_IDLE;
                    a_restart = 1'b1;
                end
            end
            MODE_IDLE, MODE_DISCARD:
            begin
            end
        endcase
    end

    // Start a fresh token
    assign b_run = (mode_reg == MODE_IDLE) || a_restart;

    always_comb begin
        b_mode  = a_mode;
        b_pend  = pend_reg;
        b_begin = begin_reg;
        b_line  = line_reg;
        b_wbuf  = a_wbuf;
        b_wlen  = a_wlen;
        if (b_run) begin
            b_begin = pos_reg;
            priority if (is_single) begin
                b_mode = MODE_IDLE;
            end
            else if (is_op) begin
                b_mode = MODE_OP;
                b_pend = op_code;
            end
            else if (is_quote) begin
                b_mode = MODE_STR;
            end
            else if (is_nl) begin
                if (line_reg != '1) b_line = line_reg + 32'd1;
            end
            else if (is_digit) begin
                b_mode = MODE_INT;
            end
            else if (is_letter) begin
                b_mode = MODE_WORD;
                b_wbuf = {56'd0, src_byte};
                b_wlen = WLEN_W'(1);
            end
            else if (is_bad) begin
                b_mode = MODE_DISCARD;
            end
            else begin
                // blanks only move the token start
            end
        end
    end

    // Next state: the last word of a run returns everything to reset values
    always_comb begin
        mode_next  = b_mode;
        pend_next  = b_pend;
        begin_next = b_begin;
        pos_next   = pos_sat;
        line_next  = b_line;
        wbuf_next  = b_wbuf;
        wlen_next  = b_wlen;
        if (src_final) begin
            mode_next  = MODE_IDLE;
            pend_next  = OP_EQ;
            begin_next = '0;
            pos_next   = '0;
            line_next  = 32'd1;
            wbuf_next  = '0;
            wlen_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= OP_EQ;
            begin_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= 32'd1;
            wbuf_reg  <= '0;
            wlen_reg  <= '0;
        end
        else if (step) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            wbuf_reg  <= wbuf_next;
            wlen_reg  <= wlen_next;
        end
    end

    // Outputs: slots 0-1 close the open token, slot 2 a fresh one, slots 3-4 end the run
    always_comb begin
        for (int k = 0; k < 5; k++) begin
            cand[k] = '0;
        end
        cand_v = '0;

        unique case (mode_reg)
            MODE_OP:
            begin
                cand_v[0] = 1'b1;
                if (is_eq) cand[0] = mk_rec(op_kind_a | 6'd1, begin_ext, p1_ext, line_reg, 8'h00);
                else       cand[0] = mk_rec(op_kind_a, begin_ext, p_ext, line_reg, 8'h00);
            end
            MODE_STR:
            begin
                cand_v[0] = is_quote;
                cand[0]   = mk_rec(KIND_STRING, begin_ext, p1_ext, line_reg, 8'h00);
            end
            MODE_INT, MODE_FRAC:
            begin
                cand_v[0] = !is_digit && !(is_dot && (mode_reg == MODE_INT));
                cand[0]   = mk_rec(KIND_NUMBER, begin_ext, p_ext, line_reg, 8'h00);
            end
            MODE_DOT:
            begin
                cand_v[0] = !is_digit;
                cand_v[1] = !is_digit;
                cand[0]   = mk_rec(KIND_NUMBER, begin_ext, pm1_ext, line_reg, 8'h00);
                cand[1]   = mk_rec(KIND_BADCHAR, pm1_ext, p_ext, line_reg, CH_DOT);
            end
            MODE_WORD:
            begin
                cand_v[0] = !(is_letter || is_digit);
                cand[0]   = mk_rec(keyword_kind(wbuf_reg, wlen_reg), begin_ext, p_ext,
                                   line_reg, 8'h00);
            end
            MODE_IDLE, MODE_DISCARD:
            begin
            end
        endcase

        if (b_run && is_single) begin
            cand_v[2] = 1'b1;
            cand[2]   = mk_rec(single_kind, p_ext, p1_ext, b_line, 8'h00);
        end
        else if (b_run && is_bad) begin
            cand_v[2] = 1'b1;
            cand[2]   = mk_rec(KIND_BADCHAR, p_ext, p1_ext, b_line, src_byte);
        end

        if (src_final) begin
            unique case (b_mode)
                MODE_OP:
                begin
                    cand_v[4:3] = 2'b11;
                    cand[3] = mk_rec(op_kind_b, b_begin_ext, pe_ext, b_line, 8'h00);
                    cand[4] = mk_rec(KIND_END, pe_ext, pe_ext, b_line, 8'h00);
                end
                MODE_STR:
                begin
                    cand_v[3] = 1'b1;
                    cand[3]   = mk_rec(KIND_UNTERM, b_begin_ext, pe_ext, b_line, 8'h00);
                end
                MODE_INT, MODE_FRAC:
                begin
                    cand_v[4:3] = 2'b11;
                    cand[3] = mk_rec(KIND_NUMBER, b_begin_ext, pe_ext, b_line, 8'h00);
                    cand[4] = mk_rec(KIND_END, pe_ext, pe_ext, b_line, 8'h00);
                end
                MODE_DOT:
                begin
                    cand_v[4:3] = 2'b11;
                    cand[3] = mk_rec(KIND_NUMBER, b_begin_ext, p_ext, b_line, 8'h00);
                    cand[4] = mk_rec(KIND_BADCHAR, p_ext, p1_ext, b_line, CH_DOT);
                end
                MODE_WORD:
                begin
                    cand_v[4:3] = 2'b11;
                    cand[3] = mk_rec(keyword_kind(b_wbuf, b_wlen), b_begin_ext, pe_ext,
                                     b_line, 8'h00);
                    cand[4] = mk_rec(KIND_END, pe_ext, pe_ext, b_line, 8'h00);
                end
                MODE_IDLE:
                begin
                    cand_v[3] = 1'b1;
                    cand[3]   = mk_rec(KIND_END, pe_ext, pe_ext, b_line, 8'h00);
                end
                MODE_DISCARD:
                begin
                end
            endcase
        end
    end

    // Pack the live slots in order and flag the last one
    always_comb begin
        recs = '0;
        idx  = 3'd0;
        for (int k = 0; k < 5; k++) begin
            if (cand_v[k] && (idx < 3'(MAX_RECS))) begin
                recs[idx[1:0]] = cand[k];
                idx = idx + 3'd1;
            end
        end
        if (idx != 3'd0) begin
            recs[2'(idx - 3'd1)].run_end = 1'b1;
        end
        rec_count = idx[1:0];
    end

endmodule

@@ hw/rtl/lts_queue.sv @@
// Result queue: takes up to three records per cycle, hands out one per cycle while pop is high.
module lts_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_count,
    input  lts_pkg::rec_t [2:0]   push_recs,
    input  logic                  pop,
    output lts_pkg::rec_t         head,
    output lts_pkg::q_status_t    status
);
    import lts_pkg::*;

    rec_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECS; i++) begin
            if (i < int'(push_count)) begin
                mem[wr_ptr_reg + QPTR_W'(i)] <= push_recs[i];
            end
        end
    end

    assign head             = mem[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RECS));

endmodule

@@ hw/rtl/lexical_token_scanner.sv @@
// Top level of the lexical token scanner: input register, scan stage and result queue.
//
// Source text streams in one byte per word on the source channel, with final_byte
// set on the last byte of a run. Each word is held in an input register and scanned
// from there, and the token records it completes (zero to three) are written into an
// eight-entry result queue; the first record of a word reaches the token channel after
// the word has left the input register and its record is queued. One source word is
// taken every cycle as long as the queue has room for three more records, and records
// leave at one per cycle, so throughput is one word per cycle unless several
// consecutive words each finish more than one token or the token side stalls. run_end
// marks the last record a word produced. After an error record (bad character or
// unterminated string) the rest of the run is dropped until final_byte; after
// final_byte the offset returns to 0 and the line count to 1. Offsets are
// POSITION_WIDTH bits wide internally and saturate; token_start carries their low
// 32 bits.
module lexical_token_scanner #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        source_valid,
    output logic        source_ready,
    input  logic [7:0]  source_byte,
    input  logic        final_byte,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [5:0]  token_kind,
    output logic [31:0] token_start,
    output logic [31:0] token_length,
    output logic [31:0] line_number,
    output logic [7:0]  offending_byte,
    output logic        run_end
);
    import lts_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  byte_reg;
    logic        final_reg;
    logic        accept;
    logic        step;

    rec_t [2:0]  recs;
    logic [1:0]  rec_count;
    logic [1:0]  push_count;
    rec_t        head;
    q_status_t   q_status;

    // Advance the held word only when the queue can take its worst case of three records
    assign step         = in_valid_reg && q_status.room;
    assign source_ready = !in_valid_reg || step;
    assign accept       = source_valid && source_ready;

    assign in_valid_next = accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the payload of the word waiting to be scanned
    always_ff @(posedge clk)
    begin
        if (accept) begin
            byte_reg  <= source_byte;
            final_reg <= final_byte;
        end
    end

    lts_scan #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .src_byte  (byte_reg),
        .src_final (final_reg),
        .recs      (recs),
        .rec_count (rec_count)
    );

    // Drop records of a word that is not advancing this cycle
    assign push_count = step ? rec_count : 2'd0;

    lts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_recs  (recs),
        .pop        (token_valid && token_ready),
        .head       (head),
        .status     (q_status)
    );

    assign token_valid    = q_status.not_empty;
    assign token_kind     = head.kind;
    assign token_start    = head.start;
    assign token_length   = head.length;
    assign line_number    = head.line;
    assign offending_byte = head.offending;
    assign run_end        = head.run_end;

endmodule

@@ hw/rtl/lts_checker.sv @@
// Port-level checker for the token scanner and its bind to the top level.
module lts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        source_valid,
    input logic        source_ready,
    input logic [7:0]  source_byte,
    input logic        final_byte,
    input logic        token_valid,
    input logic        token_ready,
    input logic [5:0]  token_kind,
    input logic [31:0] token_start,
    input logic [31:0] token_length,
    input logic [31:0] line_number,
    input logic [7:0]  offending_byte,
    input logic        run_end
);
    import lts_pkg::*;

    // A stalled record holds
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_ready |=>
            token_valid && $stable(token_kind) && $stable(token_start) &&
            $stable(token_length) && $stable(line_number) &&
            $stable(offending_byte) && $stable(run_end))
        else $error("token record changed while stalled");

    // Only a bad-character record carries an offending byte
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_kind != KIND_BADCHAR) |-> offending_byte == 8'h00)
        else $error("offending byte on a record that is not a bad character");

    // An end record is empty and closes its word
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_kind == KIND_END) |-> (token_length == 32'd0) && run_end)
        else $error("end record with nonzero length or without run_end");

    // An unterminated string is always the last record of its word
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_kind == KIND_UNTERM) |-> run_end && (line_number != 32'd0))
        else $error("unterminated string record not last in its word");

    // Lines count from one
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> line_number != 32'd0)
        else $error("line number zero");

endmodule

bind lexical_token_scanner lts_checker u_lts_checker (.*);

@@ tb/lexical_token_scanner_test.sv @@
// Self-checking testbench for the lexical token scanner: byte driver, token monitor, predictor.
module lexical_token_scanner_test;

    import lts_pkg::*;

    localparam int STALL_LIMIT  = 1000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 16;     // quiet time after the last expected token
    localparam int RANDOM_WORDS = 480;
    localparam longint unsigned POS_LIMIT = 64'hFFFF_FFFF;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } src_word_t;

    logic        clk;
    logic        rst_n;
    logic        source_valid;
    logic        source_ready;
    logic [7:0]  source_byte;
    logic        final_byte;
    logic        token_valid;
    logic        token_ready;
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic [7:0]  offending_byte;
    logic        run_end;

    lexical_token_scanner DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .source_valid   (source_valid),
        .source_ready   (source_ready),
        .source_byte    (source_byte),
        .final_byte     (final_byte),
        .token_valid    (token_valid),
        .token_ready    (token_ready),
        .token_kind     (token_kind),
        .token_start    (token_start),
        .token_length   (token_length),
        .line_number    (line_number),
        .offending_byte (offending_byte),
        .run_end        (run_end)
    );

    // Free-running clock, period 8.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Scanner predictor: a sequential copy of the tokenizer state.
    // ------------------------------------------------------------------
    mode_t           scan_state;
    logic [1:0]      held_op;          // which of = ! < > opened a two-char operator
    longint unsigned tok_origin;
    longint unsigned byte_offset;
    logic [31:0]     line_tally;
    string           word_text;        // first eight characters of the open word
    int              word_chars;       // 9 once the word runs past eight characters

    rec_t step_recs[$];                // tokens finished by the byte being scanned
    rec_t expected_tokens[$];          // tokens still owed by the scanner, oldest first

    string keyword_names [KW_COUNT] = '{
        "let", "var", "print", "true", "false", "and",
        "or", "return", "function", "if", "else", "while"
    };

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
    endfunction

    function automatic void clear_scanner();
        scan_state  = MODE_IDLE;
        held_op     = OP_EQ;
        tok_origin  = 0;
        byte_offset = 0;
        line_tally  = 32'd1;
        word_text   = "";
        word_chars  = 0;
    endfunction

    // Record one finished token; length saturates and is zero when stop precedes start.
    function automatic void push_token(logic [5:0] kind, longint unsigned start,
                                       longint unsigned stop, logic [7:0] bad);
        rec_t            r;
        longint unsigned span;
        if (step_recs.size() >= MAX_RECS)
        begin
            return;
        end
        span        = (stop >= start) ? stop - start : 0;
        r.kind      = kind;
        r.start     = 32'(start);
        r.length    = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(span);
        r.line      = line_tally;
        r.offending = bad;
        r.run_end   = 1'b0;
        step_recs.push_back(r);
    endfunction

    function automatic logic [5:0] op_kind(bit with_eq);
        return KIND_ASSIGN + {3'b000, held_op, 1'b0} + 6'(with_eq);
    endfunction

    function automatic void word_append(logic [7:0] b);
        if (word_chars < KEYWORD_MAX_CHARS)
        begin
            word_text = $sformatf("%s%c", word_text, b);
            word_chars++;
        end
        else
        begin
            word_chars = KEYWORD_MAX_CHARS + 1;
        end
    endfunction

    function automatic logic [5:0] word_class();
        if (word_chars > KEYWORD_MAX_CHARS)
        begin
            return KIND_IDENT;
        end
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (word_text == keyword_names[i])
            begin
                return KIND_LET + 6'(i);
            end
        end
        return KIND_IDENT;
    endfunction

    // Byte seen with no token open.
    function automatic void start_token(logic [7:0] b, longint unsigned p);
        tok_origin = p;
        case (b)
            CH_PLUS:   push_token(KIND_PLUS,   p, p + 1, 8'h00);
            CH_MINUS:  push_token(KIND_MINUS,  p, p + 1, 8'h00);
            CH_STAR:   push_token(KIND_STAR,   p, p + 1, 8'h00);
            CH_SLASH:  push_token(KIND_SLASH,  p, p + 1, 8'h00);
            CH_SEMI:   push_token(KIND_SEMI,   p, p + 1, 8'h00);
            CH_COMMA:  push_token(KIND_COMMA,  p, p + 1, 8'h00);
            CH_LPAREN: push_token(KIND_LPAREN, p, p + 1, 8'h00);
            CH_RPAREN: push_token(KIND_RPAREN, p, p + 1, 8'h00);
            CH_LBRACE: push_token(KIND_LBRACE, p, p + 1, 8'h00);
            CH_RBRACE: push_token(KIND_RBRACE, p, p + 1, 8'h00);
            CH_EQ:
            begin
                held_op    = OP_EQ;
                scan_state = MODE_OP;
            end
            CH_BANG:
            begin
                held_op    = OP_BANG;
                scan_state = MODE_OP;
            end
            CH_LT:
            begin
                held_op    = OP_LT;
                scan_state = MODE_OP;
            end
            CH_GT:
            begin
                held_op    = OP_GT;
                scan_state = MODE_OP;
            end
            CH_QUOTE:
            begin
                scan_state = MODE_STR;
            end
            CH_SPACE, CH_CR, CH_TAB:
            begin
            end
            CH_NL:
            begin
                if (line_tally != 32'hFFFF_FFFF)
                begin
                    line_tally++;
                end
            end
            default:
            begin
                if (is_digit(b))
                begin
                    scan_state = MODE_INT;
                end
                else if (is_letter(b))
                begin
                    word_text  = "";
                    word_chars = 0;
                    word_append(b);
                    scan_state = MODE_WORD;
                end
                else
                begin
                    push_token(KIND_BADCHAR, p, p + 1, b);
                    scan_state = MODE_DISCARD;
                end
            end
        endcase
    endfunction

    // Byte seen with a token open; returns 1 when the byte must be scanned afresh.
    function automatic bit extend_token(logic [7:0] b, longint unsigned p);
        case (scan_state)
            MODE_OP:
            begin
                scan_state = MODE_IDLE;
                if (b == CH_EQ)
                begin
                    push_token(op_kind(1'b1), tok_origin, p + 1, 8'h00);
                    return 1'b0;
                end
                push_token(op_kind(1'b0), tok_origin, p, 8'h00);
                return 1'b1;
            end
            MODE_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    push_token(KIND_STRING, tok_origin, p + 1, 8'h00);
                    scan_state = MODE_IDLE;
                end
                return 1'b0;
            end
            MODE_INT:
            begin
                if (is_digit(b))
                begin
                    return 1'b0;
                end
                if (b == CH_DOT)
                begin
                    scan_state = MODE_DOT;
                    return 1'b0;
                end
                push_token(KIND_NUMBER, tok_origin, p, 8'h00);
                scan_state = MODE_IDLE;
                return 1'b1;
            end
            MODE_DOT:
            begin
                if (is_digit(b))
                begin
                    scan_state = MODE_FRAC;
                    return 1'b0;
                end
                // Dot not followed by a digit: the number stops before it.
                push_token(KIND_NUMBER, tok_origin, p - 1, 8'h00);
                push_token(KIND_BADCHAR, p - 1, p, CH_DOT);
                scan_state = MODE_DISCARD;
                return 1'b0;
            end
            MODE_FRAC:
            begin
                if (is_digit(b))
                begin
                    return 1'b0;
                end
                push_token(KIND_NUMBER, tok_origin, p, 8'h00);
                scan_state = MODE_IDLE;
                return 1'b1;
            end
            MODE_WORD:
            begin
                if (is_letter(b) || is_digit(b))
                begin
                    word_append(b);
                    return 1'b0;
                end
                push_token(word_class(), tok_origin, p, 8'h00);
                scan_state = MODE_IDLE;
                return 1'b1;
            end
            MODE_DISCARD:
            begin
                return 1'b0;
            end
            default:
            begin
                scan_state = MODE_IDLE;
                return 1'b1;
            end
        endcase
    endfunction

    // Close the run on its last byte at offset p; e is the offset just past it.
    function automatic void close_run(longint unsigned p, longint unsigned e);
        case (scan_state)
            MODE_OP:
            begin
                push_token(op_kind(1'b0), tok_origin, e, 8'h00);
            end
            MODE_STR:
            begin
                push_token(KIND_UNTERM, tok_origin, e, 8'h00);
                return;
            end
            MODE_INT, MODE_FRAC:
            begin
                push_token(KIND_NUMBER, tok_origin, e, 8'h00);
            end
            MODE_DOT:
            begin
                push_token(KIND_NUMBER, tok_origin, p, 8'h00);
                push_token(KIND_BADCHAR, p, p + 1, CH_DOT);
                return;
            end
            MODE_WORD:
            begin
                push_token(word_class(), tok_origin, e, 8'h00);
            end
            MODE_DISCARD:
            begin
                return;
            end
            default:
            begin
            end
        endcase
        push_token(KIND_END, e, e, 8'h00);
    endfunction

    // Advance the predictor by one accepted byte and queue the tokens it owes.
    function automatic void scan_byte(logic [7:0] b, logic fin);
        longint unsigned p;
        bit              restart;
        p = byte_offset;
        step_recs.delete();
        restart = (scan_state == MODE_IDLE) ? 1'b1 : extend_token(b, p);
        if (restart)
        begin
            start_token(b, p);
        end
        if (byte_offset < POS_LIMIT)
        begin
            byte_offset++;
        end
        if (fin)
        begin
            close_run(p, byte_offset);
            clear_scanner();
        end
        if (step_recs.size() > 0)
        begin
            step_recs[step_recs.size() - 1].run_end = 1'b1;
        end
        foreach (step_recs[i])
        begin
            expected_tokens.push_back(step_recs[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: pending source words, built before reset is released.
    // ------------------------------------------------------------------
    src_word_t pending_words[$];

    function automatic void add_byte(logic [7:0] b, logic fin);
        src_word_t w;
        w.data = b;
        w.last = fin;
        pending_words.push_back(w);
    endfunction

    // Queue a piece of text; fin marks its last character as the end of the run.
    function automatic void add_text(string s, bit fin);
        for (int i = 0; i < s.len(); i++)
        begin
            add_byte(s[i], fin && (i == s.len() - 1));
        end
    endfunction

    function automatic string append_pick(string s, string choices);
        return $sformatf("%s%c", s, choices[$urandom_range(0, choices.len() - 1)]);
    endfunction

    // One lexically valid token with random content.
    function automatic string make_token();
        string letters;
        string digits;
        string s;
        logic [7:0] c;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        digits  = "0123456789";
        s       = "";
        case ($urandom_range(0, 5))
            0, 5:
            begin
                s = keyword_names[$urandom_range(0, KW_COUNT - 1)];
            end
            1:
            begin
                // Lengths up to eleven reach past the keyword buffer.
                s = append_pick(s, letters);
                repeat ($urandom_range(0, 10))
                begin
                    s = append_pick(s, ($urandom_range(0, 3) == 0) ? digits : letters);
                end
            end
            2:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    s = append_pick(s, digits);
                end
                if ($urandom_range(0, 4) < 2)
                begin
                    s = {s, "."};
                    repeat ($urandom_range(1, 3))
                    begin
                        s = append_pick(s, digits);
                    end
                end
            end
            3:
            begin
                s = "\"";
                repeat ($urandom_range(0, 6))
                begin
                    c = ($urandom_range(0, 5) == 0) ? CH_NL : 8'($urandom_range(32, 126));
                    if (c == CH_QUOTE)
                    begin
                        c = CH_SPACE;
                    end
                    s = $sformatf("%s%c", s, c);
                end
                s = {s, "\""};
            end
            default:
            begin
                s = append_pick(s, "+-*/;,(){}=!<>=!<>");
                if ((s == "=" || s == "!" || s == "<" || s == ">") && $urandom_range(0, 1))
                begin
                    s = {s, "="};
                end
            end
        endcase
        return s;
    endfunction

    function automatic string make_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return " ";
            5:             return "\t";
            6:             return "\n";
            7:             return "\r";
            default:       return "";
        endcase
    endfunction

    // A run of valid tokens that closes with final_byte on its last character.
    function automatic void add_clean_run();
        string s;
        s = "";
        repeat ($urandom_range(1, 8))
        begin
            s = {s, make_token(), make_gap()};
        end
        add_text(s, 1'b1);
    endfunction

    // A byte that no token can begin with.
    function automatic logic [7:0] pick_bad_byte();
        string punct;
        punct = "@#$%^&~`?:[]|\\'";
        case ($urandom_range(0, 3))
            0:       return punct[$urandom_range(0, punct.len() - 1)];
            1:       return 8'($urandom_range(128, 255));
            2:       return 8'($urandom_range(0, 8));
            default: return 8'h7F;
        endcase
    endfunction

    // Runs that end in an error record, plus raw noise.
    function automatic void add_broken_run();
        string s;
        s = {make_token(), " "};
        case ($urandom_range(0, 4))
            0:
            begin
                add_text({s, "\"open", make_gap(), "text"}, 1'b1);
            end
            1:
            begin
                add_text({s, "42."}, 1'b1);
            end
            2:
            begin
                s = {s, "9."};
                s = append_pick(s, "xQ_+;( ");
                add_text({s, make_token(), " ", make_token()}, 1'b1);
            end
            3:
            begin
                add_text(s, 1'b0);
                add_byte(pick_bad_byte(), 1'b0);
                add_text({" ", make_token(), make_gap(), make_token()}, 1'b1);
            end
            default:
            begin
                // Raw bytes: every bit pattern, with final_byte falling anywhere.
                repeat ($urandom_range(1, 10))
                begin
                    add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
                end
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver, monitor and watchdog.
    // ------------------------------------------------------------------
    int src_gap;
    int sink_gap;
    bit src_calm;
    bit sink_calm;
    bit src_fire;          // a source word moved at the last rising edge
    bit tok_fire;          // a token word moved at the last rising edge
    int quiet_cycles;
    int fail_count;
    int tokens_checked;

    function automatic int pick_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at token %0d: %s", tokens_checked, msg);
        fail_count++;
    endtask

    // Compare one token word against the oldest expectation, field by field.
    task automatic check_token();
        rec_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("unexpected token kind %0d start %0d",
                                      token_kind, token_start));
            return;
        end
        want = expected_tokens.pop_front();
        if (token_kind !== want.kind)
        begin
            report_mismatch($sformatf("kind %0d, expected %0d", token_kind, want.kind));
        end
        if (token_start !== want.start)
        begin
            report_mismatch($sformatf("start %0d, expected %0d", token_start, want.start));
        end
        if (token_length !== want.length)
        begin
            report_mismatch($sformatf("length %0d, expected %0d", token_length, want.length));
        end
        if (line_number !== want.line)
        begin
            report_mismatch($sformatf("line %0d, expected %0d", line_number, want.line));
        end
        if (offending_byte !== want.offending)
        begin
            report_mismatch($sformatf("offending byte %0h, expected %0h",
                                      offending_byte, want.offending));
        end
        if (run_end !== want.run_end)
        begin
            report_mismatch($sformatf("run_end %0b, expected %0b", run_end, want.run_end));
        end
    endtask

    // Sample both handshakes at the rising edge; predict on accepted bytes,
    // check accepted tokens, and stop the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            src_fire = source_valid && source_ready;
            tok_fire = token_valid && token_ready;
            if (src_fire)
            begin
                scan_byte(source_byte, final_byte);
            end
            if (tok_fire)
            begin
                check_token();
                tokens_checked++;
            end
            if (src_fire || tok_fire)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Drive at the falling edge. Hold valid and payload until the word moves,
    // then idle for the drawn gap before presenting the next word. Each side
    // switches now and then into a calm stretch with no idling at all.
    always @(negedge clk)
    begin
        src_word_t w;
        bit        drive_valid;
        if (rst_n)
        begin
            drive_valid = source_valid;
            if (!source_valid || src_fire)
            begin
                drive_valid = 1'b0;
                if (src_gap > 0)
                begin
                    src_gap--;
                end
                else if (pending_words.size() > 0)
                begin
                    w            = pending_words.pop_front();
                    source_byte <= w.data;
                    final_byte  <= w.last;
                    drive_valid  = 1'b1;
                    if ($urandom_range(0, 19) == 0)
                    begin
                        src_calm = !src_calm;
                    end
                    src_gap = pick_gap(src_calm);
                end
            end
            source_valid <= drive_valid;

            // Drop ready for a drawn number of cycles after every token word.
            if (tok_fire)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    sink_calm = !sink_calm;
                end
                sink_gap = pick_gap(sink_calm);
                tok_fire = 1'b0;
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                token_ready <= 1'b0;
            end
            else
            begin
                token_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int target;
        rst_n        = 1'b0;
        source_valid = 1'b0;
        source_byte  = 8'h00;
        final_byte   = 1'b0;
        token_ready  = 1'b0;
        src_gap      = 0;
        sink_gap     = $urandom_range(0, 12);
        src_calm     = 1'b0;
        sink_calm    = 1'b0;
        src_fire     = 1'b0;
        tok_fire     = 1'b0;
        quiet_cycles = 0;
        fail_count   = 0;
        tokens_checked = 0;
        clear_scanner();

        // Directed runs: two-char and trailing operators, a string broken by
        // the end with a newline inside, a dot with no digit after it followed
        // by discarded input, NUL and high bytes, a lone operator closed by the
        // end, and a keyword with a decimal.
        add_text("<=!=>", 1'b1);
        add_text("\"a\nb", 1'b1);
        add_text("7.x;", 1'b1);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_text("=", 1'b1);
        add_text("while 3.2", 1'b1);

        // Random part: mostly well-formed runs, the rest errors and noise.
        target = pending_words.size() + RANDOM_WORDS;
        while (pending_words.size() < target)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_broken_run();
            end
            else
            begin
                add_clean_run();
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every word to move and every expected token to arrive,
        // then keep watching for stray tokens.
        while (pending_words.size() != 0 || source_valid)
        begin
            @(negedge clk);
        end
        while (expected_tokens.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
